FILE: rtl/gnd_pkg.sv
// shared types and constants for the graph node diffusion update block
// no dependencies
`default_nettype none
package gnd_pkg;
    localparam int LANES      = 3;
    localparam int CONC_W     = 18;
    localparam int LEN_W      = 16;
    localparam int IDX_W      = 12;
    localparam int GAIN_W     = 32;
    localparam int QUO_W      = CONC_W + 16;
    localparam int TERM_W     = QUO_W + 1;
    localparam int TOTAL_W    = TERM_W + 2;
    localparam int MAG_W      = TOTAL_W - 1;
    localparam int SUML_W     = LEN_W + 2;
    localparam int PROD_W     = MAG_W + 17;
    localparam int DELTA_W    = CONC_W + 1;
    localparam logic [CONC_W-1:0] CONC_MAX = '1;

    typedef struct packed {
        logic [IDX_W-1:0]  node;
        logic [CONC_W-1:0] own;
    } t_item;

    typedef struct packed {
        logic              usable;
        logic [LEN_W-1:0]  len;
        logic [TERM_W-1:0] term;
    } t_lane_res;

    typedef struct packed {
        t_item item;
        logic  neg;
        logic  any;
        logic  ovf;
    } t_div_pay;
endpackage
`default_nettype wire

FILE: rtl/gnd_div.sv
// pipelined restoring divider, one quotient bit per stage, with sideband payload
// no dependencies
`default_nettype none
module gnd_div #(
    parameter int N  = 34,
    parameter int D  = 16,
    parameter int Q  = 34,
    parameter int PW = 1
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_en,
    input  wire          i_valid,
    input  wire [N-1:0]  i_num,
    input  wire [D-1:0]  i_den,
    input  wire [PW-1:0] i_pay,
    output logic          o_valid,
    output logic [Q-1:0]  o_quo,
    output logic [PW-1:0] o_pay
);
    logic [N-1:0]  st_rem [0:Q];
    logic [D-1:0]  st_den [0:Q];
    logic [Q-1:0]  st_quo [0:Q];
    logic [PW-1:0] st_pay [0:Q];
    logic          st_vld [0:Q];

    assign st_rem[0] = i_num;
    assign st_den[0] = i_den;
    assign st_quo[0] = '0;
    assign st_pay[0] = i_pay;
    assign st_vld[0] = i_valid;

    for (genvar s = 0; s < Q; s++) begin : g_stage
        localparam int B = Q - 1 - s;
        logic [N+D:0]  w_sub;
        logic [N+D:0]  w_dif;
        logic [N-1:0]  r_rem;
        logic [D-1:0]  r_den;
        logic [Q-1:0]  r_quo;
        logic [PW-1:0] r_pay;
        logic          r_vld;

        assign w_sub = {{(N+1){1'b0}}, st_den[s]} << B;
        assign w_dif = {{(D+1){1'b0}}, st_rem[s]} - w_sub;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld <= 1'b0;
            end else if (i_en) begin
                r_vld <= st_vld[s];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_den <= st_den[s];
                r_pay <= st_pay[s];
                if (!w_dif[N+D]) begin
                    r_rem <= w_dif[N-1:0];
                    r_quo <= st_quo[s] | ({{(Q-1){1'b0}}, 1'b1} << B);
                end else begin
                    r_rem <= st_rem[s];
                    r_quo <= st_quo[s];
                end
            end
        end

        assign st_rem[s+1] = r_rem;
        assign st_den[s+1] = r_den;
        assign st_quo[s+1] = r_quo;
        assign st_pay[s+1] = r_pay;
        assign st_vld[s+1] = r_vld;
    end

    assign o_valid = st_vld[Q];
    assign o_quo   = st_quo[Q];
    assign o_pay   = st_pay[Q];
endmodule
`default_nettype wire

FILE: rtl/gnd_lane.sv
// one neighbour lane: signed flux term (c - own) * 2^16 / len
// depends on gnd_pkg and gnd_div
`default_nettype none
module gnd_lane (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire                       i_en,
    input  wire                       i_valid,
    input  wire [gnd_pkg::CONC_W-1:0] i_conc,
    input  wire [gnd_pkg::CONC_W-1:0] i_own,
    input  wire [gnd_pkg::LEN_W-1:0]  i_len,
    input  wire                       i_nb_ok,
    output logic                      o_valid,
    output gnd_pkg::t_lane_res        o_res
);
    import gnd_pkg::*;

    logic              w_neg;
    logic [CONC_W-1:0] w_diff;
    logic              w_use;
    logic [QUO_W-1:0]  w_quo;
    logic [LEN_W+1:0]  w_pay_in;
    logic [LEN_W+1:0]  w_pay_out;
    logic [TERM_W-1:0] w_mag;

    assign w_neg  = i_conc < i_own;
    assign w_diff = w_neg ? (i_own - i_conc) : (i_conc - i_own);
    assign w_use  = i_nb_ok && (i_len != '0);
    assign w_pay_in = {w_use, w_neg, i_len};

    gnd_div #(.N(QUO_W), .D(LEN_W), .Q(QUO_W), .PW(LEN_W + 2)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (i_en),
        .i_valid (i_valid),
        .i_num   ({w_diff, 16'd0}),
        .i_den   (i_len),
        .i_pay   (w_pay_in),
        .o_valid (o_valid),
        .o_quo   (w_quo),
        .o_pay   (w_pay_out)
    );

    assign w_mag = {1'b0, w_quo};

    always_comb begin
        o_res.usable = w_pay_out[LEN_W+1];
        o_res.len    = w_pay_out[LEN_W-1:0];
        if (!w_pay_out[LEN_W+1]) begin
            o_res.term = '0;
        end else if (w_pay_out[LEN_W]) begin
            o_res.term = -w_mag;
        end else begin
            o_res.term = w_mag;
        end
    end
endmodule
`default_nettype wire

FILE: rtl/gnd_merge.sv
// merging stage: sums lane terms, scales by gain, divides by total length, saturates
// depends on gnd_pkg and gnd_div
`default_nettype none
module gnd_merge (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_en,
    input  wire                        i_valid,
    input  wire gnd_pkg::t_item        i_item,
    input  wire gnd_pkg::t_lane_res [2:0] i_res,
    input  wire [gnd_pkg::GAIN_W-1:0]  i_gain,
    output logic                       o_valid,
    output logic [gnd_pkg::IDX_W-1:0]  o_node,
    output logic [gnd_pkg::CONC_W-1:0] o_conc,
    output logic                       o_clamped,
    output logic                       o_isolated
);
    import gnd_pkg::*;

    // sum stage
    logic               r1_vld;
    t_item              r1_item;
    logic [TOTAL_W-1:0] r1_total;
    logic [SUML_W-1:0]  r1_suml;
    logic               r1_any;
    // magnitude stage
    logic               r2_vld;
    t_item              r2_item;
    logic [MAG_W-1:0]   r2_mag;
    logic               r2_neg;
    logic [SUML_W-1:0]  r2_suml;
    logic               r2_any;
    // product stage
    logic               r3_vld;
    t_item              r3_item;
    logic [MAG_W+15:0]  r3_phi;
    logic [MAG_W+15:0]  r3_plo;
    logic               r3_neg;
    logic [SUML_W-1:0]  r3_suml;
    logic               r3_any;
    // combine stage
    logic               r4_vld;
    t_item              r4_item;
    logic [PROD_W-1:0]  r4_prod;
    logic               r4_neg;
    logic [SUML_W-1:0]  r4_suml;
    logic               r4_any;

    logic [TOTAL_W-1:0] n1_total;
    logic [SUML_W-1:0]  n1_suml;
    logic               w4_ovf;
    t_div_pay           w_pay_in;
    t_div_pay           w_pay_out;
    logic               w_dvld;
    logic [DELTA_W-1:0] w_delta;
    logic [DELTA_W:0]   w_sum;

    always_comb begin
        n1_total = '0;
        n1_suml  = '0;
        for (int k = 0; k < LANES; k++) begin
            n1_total = n1_total + {{(TOTAL_W-TERM_W){i_res[k].term[TERM_W-1]}}, i_res[k].term};
            if (i_res[k].usable) begin
                n1_suml = n1_suml + {{(SUML_W-LEN_W){1'b0}}, i_res[k].len};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
            r4_vld <= 1'b0;
        end else if (i_en) begin
            r1_vld <= i_valid;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
            r4_vld <= r3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_item  <= i_item;
            r1_total <= n1_total;
            r1_suml  <= n1_suml;
            r1_any   <= i_res[0].usable | i_res[1].usable | i_res[2].usable;

            r2_item  <= r1_item;
            r2_neg   <= r1_total[TOTAL_W-1];
            r2_mag   <= r1_total[TOTAL_W-1] ? MAG_W'(-r1_total) : r1_total[MAG_W-1:0];
            r2_suml  <= r1_suml;
            r2_any   <= r1_any;

            r3_item  <= r2_item;
            r3_phi   <= {{MAG_W{1'b0}}, i_gain[31:16]} * {16'd0, r2_mag};
            r3_plo   <= {{MAG_W{1'b0}}, i_gain[15:0]} * {16'd0, r2_mag};
            r3_neg   <= r2_neg;
            r3_suml  <= r2_suml;
            r3_any   <= r2_any;

            r4_item  <= r3_item;
            r4_prod  <= {1'b0, r3_phi} + {17'd0, r3_plo[MAG_W+15:16]};
            r4_neg   <= r3_neg;
            r4_suml  <= r3_suml;
            r4_any   <= r3_any;
        end
    end

    assign w4_ovf = r4_prod >= {{(PROD_W-SUML_W-DELTA_W){1'b0}}, r4_suml, {DELTA_W{1'b0}}};

    always_comb begin
        w_pay_in.item = r4_item;
        w_pay_in.neg  = r4_neg;
        w_pay_in.any  = r4_any;
        w_pay_in.ovf  = w4_ovf;
    end

    gnd_div #(.N(PROD_W), .D(SUML_W), .Q(DELTA_W), .PW($bits(t_div_pay))) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (i_en),
        .i_valid (r4_vld),
        .i_num   (r4_prod),
        .i_den   (r4_suml),
        .i_pay   (w_pay_in),
        .o_valid (w_dvld),
        .o_quo   (w_delta),
        .o_pay   (w_pay_out)
    );

    assign w_sum = {2'b00, w_pay_out.item.own} + {1'b0, w_delta};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= w_dvld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_node <= w_pay_out.item.node;
            if (!w_pay_out.any) begin
                o_conc     <= w_pay_out.item.own;
                o_clamped  <= 1'b0;
                o_isolated <= 1'b1;
            end else if (w_pay_out.neg) begin
                o_isolated <= 1'b0;
                if (w_pay_out.ovf || (w_delta > {1'b0, w_pay_out.item.own})) begin
                    o_conc    <= '0;
                    o_clamped <= 1'b1;
                end else begin
                    o_conc    <= w_pay_out.item.own - w_delta[CONC_W-1:0];
                    o_clamped <= 1'b0;
                end
            end else begin
                o_isolated <= 1'b0;
                if (w_pay_out.ovf || (w_sum > {2'b00, CONC_MAX})) begin
                    o_conc    <= CONC_MAX;
                    o_clamped <= 1'b1;
                end else begin
                    o_conc    <= w_sum[CONC_W-1:0];
                    o_clamped <= 1'b0;
                end
            end
        end
    end
endmodule
`default_nettype wire

FILE: rtl/graph_node_diffusion_update.sv
// channel   dir  tdata                                   tuser
// s_axis    in   node,own,conc a/b/c,len a/b/c (136b)    nb_valid (3b)
// m_axis    out  node_index_out,new_conc (32b)           clamped,isolated (2b)
// cfg       in   diffusion_gain (32b), write enable only  -
// one transaction per cycle while the output is not stalled; the pipeline runs through the per-lane
// dividers, four merge stages, the length divider and one output register
// the whole pipeline advances together; it halts only while the output register is full
// and not taken; reset is synchronous, gain resets to zero
// top level: lanes, pass-through delay line, merge; depends on gnd_pkg, gnd_lane, gnd_merge
`default_nettype none
module graph_node_diffusion_update (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_s_tvalid,
    output logic        o_s_tready,
    // node_index, own_conc, nb_conc_a, nb_conc_b, nb_conc_c, seg_len_a, seg_len_b, seg_len_c
    input  wire [135:0] i_s_tdata,
    // nb_valid
    input  wire [2:0]   i_s_tuser,
    output logic        o_m_tvalid,
    input  wire         i_m_tready,
    // node_index_out, new_conc, two zero bits
    output logic [31:0] o_m_tdata,
    // clamped, isolated
    output logic [1:0]  o_m_tuser,
    input  wire         i_cfg_we,
    input  wire [31:0]  i_cfg_wdata
);
    import gnd_pkg::*;

    localparam int DLY = QUO_W;

    logic                    r_gain;
    logic [GAIN_W-1:0]       r_gain_q;
    logic                    w_en;
    t_item                   w_item;
    t_item                   r_dly [0:DLY-1];
    t_lane_res [2:0]         w_res;
    logic [LANES-1:0]        w_lvld;
    logic [IDX_W-1:0]        w_node;
    logic [CONC_W-1:0]       w_conc;
    logic                    w_clamped;
    logic                    w_isolated;
    logic [CONC_W-1:0]       w_nbc [0:LANES-1];
    logic [LEN_W-1:0]        w_len [0:LANES-1];

    assign w_en       = !o_m_tvalid || i_m_tready;
    assign o_s_tready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_q <= '0;
            r_gain   <= 1'b0;
        end else if (i_cfg_we) begin
            r_gain_q <= i_cfg_wdata;
            r_gain   <= 1'b1;
        end
    end

    assign w_item.node = i_s_tdata[11:0];
    assign w_item.own  = i_s_tdata[29:12];
    assign w_nbc[0]    = i_s_tdata[47:30];
    assign w_nbc[1]    = i_s_tdata[65:48];
    assign w_nbc[2]    = i_s_tdata[83:66];
    assign w_len[0]    = i_s_tdata[99:84];
    assign w_len[1]    = i_s_tdata[115:100];
    assign w_len[2]    = i_s_tdata[131:116];

    for (genvar k = 0; k < LANES; k++) begin : g_lane
        gnd_lane u_lane (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (i_s_tvalid && w_en),
            .i_conc  (w_nbc[k]),
            .i_own   (w_item.own),
            .i_len   (w_len[k]),
            .i_nb_ok (i_s_tuser[k]),
            .o_valid (w_lvld[k]),
            .o_res   (w_res[k])
        );
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dly[0] <= w_item;
            for (int k = 1; k < DLY; k++) begin
                r_dly[k] <= r_dly[k-1];
            end
        end
    end

    gnd_merge u_merge (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (w_en),
        .i_valid    (w_lvld[0]),
        .i_item     (r_dly[DLY-1]),
        .i_res      (w_res),
        .i_gain     (r_gain ? r_gain_q : '0),
        .o_valid    (o_m_tvalid),
        .o_node     (w_node),
        .o_conc     (w_conc),
        .o_clamped  (w_clamped),
        .o_isolated (w_isolated)
    );

    assign o_m_tdata = {2'b00, w_conc, w_node};
    assign o_m_tuser = {w_isolated, w_clamped};

    a_lanes_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(w_lvld) == 0 || w_lvld == {LANES{1'b1}})
        else $error("lanes out of step");

    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> !(o_m_tuser[0] && o_m_tuser[1]))
        else $error("clamped and isolated together");

    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> o_m_tvalid)
        else $error("input stalled with empty output");

    a_empty_after_reset: assert property (@(posedge i_clk)
        i_rst_n && $past(!i_rst_n) |-> !o_m_tvalid)
        else $error("output valid straight after reset");
endmodule
`default_nettype wire
